### rtl/rv64i_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// rv64i_execute_unit_assert.svh
// Assertion macros for the execute unit back end (rvex_back).
// ----------------------------------------------------------------------------
`ifndef RV64I_EXECUTE_UNIT_ASSERT_SVH
`define RV64I_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RVEX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RVEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Types, opcodes and decode helpers for the RV64I execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvex_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_SRL  = 6'h00;
    localparam logic [5:0] F6_SRA  = 6'h10;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    localparam logic [2:0] F3_JALR = 3'd0;

    typedef enum logic [3:0] {
        KIND_ALU, KIND_LOAD, KIND_STORE, KIND_LUI, KIND_AUIPC,
        KIND_JAL, KIND_JALR, KIND_BRANCH, KIND_BAD
    } kind_t;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
        ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
    } alu_t;

    typedef enum logic [1:0] {
        ST_CLEAR, ST_READ, ST_EXEC, ST_WB
    } state_t;

    typedef struct packed {
        kind_t       kind;
        alu_t        alu;
        logic        use_imm;
        logic [63:0] imm;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
    } dec_t;

    typedef struct packed {
        logic avail;
        dec_t head;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    function automatic alu_t base_alu(input logic [2:0] f3);
        alu_t r;
        unique case (f3)
            F3_ADD:  r = ALU_ADD;
            F3_SLL:  r = ALU_SLL;
            F3_SLT:  r = ALU_SLT;
            F3_SLTU: r = ALU_SLTU;
            F3_XOR:  r = ALU_XOR;
            F3_SR:   r = ALU_SRL;
            F3_OR:   r = ALU_OR;
            default: r = ALU_AND;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/rvex_ram.sv
// ----------------------------------------------------------------------------
// rvex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/rvex_front.sv
// ----------------------------------------------------------------------------
// rvex_front
// Accepts instruction words, decodes them and queues them (two entries).
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         instr_word,
    output rvex_pkg::q_head_t   q_head,
    input  rvex_pkg::back_ctl_t back_ctl
);

    import rvex_pkg::*;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_j;
    logic [63:0] imm_u;
    dec_t        d;

    dec_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    assign op = instr_word[6:0];
    assign f3 = instr_word[14:12];
    assign f7 = instr_word[31:25];
    assign f6 = instr_word[31:26];

    assign imm_i = {{52{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{52{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{51{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {{43{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};
    assign imm_u = {{32{instr_word[31]}}, instr_word[31:12], 12'b0};

    always_comb
    begin
        d         = '0;
        d.kind    = KIND_BAD;
        d.alu     = ALU_ADD;
        d.use_imm = 1'b0;
        d.imm     = imm_i;
        d.f3      = f3;
        d.rd      = instr_word[11:7];
        d.rs1     = instr_word[19:15];
        d.rs2     = instr_word[24:20];
        unique case (op)
            OPC_OP:
            begin
                d.kind = KIND_ALU;
                priority if (f7 == F7_BASE)
                    d.alu = base_alu(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    d.alu = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    d.alu = ALU_SRA;
                else
                    d.kind = KIND_BAD;
            end
            OPC_OPIMM:
            begin
                d.kind    = KIND_ALU;
                d.use_imm = 1'b1;
                priority if (f3 == F3_SLL)
                begin
                    if (f6 == F6_SRL)
                        d.alu = ALU_SLL;
                    else
                        d.kind = KIND_BAD;
                end
                else if (f3 == F3_SR)
                begin
                    priority if (f6 == F6_SRL)
                        d.alu = ALU_SRL;
                    else if (f6 == F6_SRA)
                        d.alu = ALU_SRA;
                    else
                        d.kind = KIND_BAD;
                end
                else
                    d.alu = base_alu(f3);
            end
            OPC_LOAD:
            begin
                if (f3 != F3_AND)
                    d.kind = KIND_LOAD;
            end
            OPC_STORE:
            begin
                d.imm = imm_s;
                if (!f3[2])
                    d.kind = KIND_STORE;
            end
            OPC_LUI:
            begin
                d.kind = KIND_LUI;
                d.imm  = imm_u;
            end
            OPC_AUIPC:
            begin
                d.kind = KIND_AUIPC;
                d.imm  = imm_u;
            end
            OPC_JAL:
            begin
                d.kind = KIND_JAL;
                d.imm  = imm_j;
            end
            OPC_JALR:
            begin
                if (f3 == F3_JALR)
                    d.kind = KIND_JALR;
            end
            OPC_BRANCH:
            begin
                d.imm = imm_b;
                if (f3 != F3_SLT && f3 != F3_SLTU)
                    d.kind = KIND_BRANCH;
            end
            default:
            begin
                d.kind = KIND_BAD;
            end
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2) || back_ctl.clearing;
    assign push     = in_valid && !in_stall;
    assign pop      = back_ctl.pop && (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= d;
    end

    assign q_head.avail = (cnt_reg != 2'd0);
    assign q_head.head  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### rtl/rvex_back.sv
// ----------------------------------------------------------------------------
// rvex_back
// Executes queued instructions: register read, execute and memory access,
// writeback. Holds the register file, program counter and data memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv64i_execute_unit_assert.svh"

module rvex_back #(
    parameter int MEM_BYTES = rvex_pkg::MEM_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rvex_pkg::q_head_t   q_head,
    output rvex_pkg::back_ctl_t back_ctl,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         next_pc,
    output logic                reg_written,
    output logic [4:0]          reg_index,
    output logic signed [63:0]  reg_value,
    output logic                mem_written,
    output logic [15:0]         mem_address,
    output logic [3:0]          mem_bytes,
    output logic                unsupported
);

    import rvex_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / 8;
    localparam int ROW_W  = ADDR_W - 3;

    state_t             state_reg;
    state_t             state_next;
    logic [31:0]        pc_reg;
    logic [31:0]        reg_valid_reg;
    logic [ROW_W-1:0]   clr_row_reg;
    dec_t               dec_reg;
    logic               rs1_ok_reg;
    logic               rs2_ok_reg;

    logic [63:0]        ex_val_reg;
    logic [31:0]        ex_npc_reg;
    logic               ex_wr_reg;
    logic               ex_st_reg;
    logic [ADDR_W-1:0]  ex_addr_reg;

    logic               out_valid_reg;
    logic [31:0]        next_pc_reg;
    logic               reg_written_reg;
    logic [4:0]         reg_index_reg;
    logic [63:0]        reg_value_reg;
    logic               mem_written_reg;
    logic [15:0]        mem_address_reg;
    logic [3:0]         mem_bytes_reg;
    logic               unsupported_reg;

    logic               rf_re;
    logic [63:0]        rf_a_rdata;
    logic [63:0]        rf_b_rdata;
    logic               rf_we;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [63:0]        opb;
    logic [63:0]        alu_res;
    logic [63:0]        eff;
    logic [63:0]        link;
    logic [31:0]        pc4;
    logic               taken;
    logic [63:0]        ex_val;
    logic [31:0]        ex_npc;
    logic               ex_wr;
    logic               clearing;
    logic               exec_store;
    logic               exec_load;
    logic [ADDR_W-1:0]  mem_addr;
    logic [2:0]         mem_lo;
    logic [ROW_W-1:0]   mem_row;
    logic [3:0]         st_bytes;
    logic [7:0]         bank_rdata [8];
    logic [7:0]         bank_we;
    logic [63:0]        ld_raw;
    logic [63:0]        ld_val;
    logic [63:0]        wb_val;
    logic               wb_fire;
    logic [ADDR_W+15:0] addr_ext;

    // ---------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_row_reg == {ROW_W{1'b1}})
                    state_next = ST_READ;
            ST_READ:
                if (q_head.avail)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = ST_WB;
            ST_WB:
                if (wb_fire)
                    state_next = ST_READ;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    assign clearing          = (state_reg == ST_CLEAR);
    assign rf_re             = (state_reg == ST_READ) && q_head.avail;
    assign back_ctl.pop      = rf_re;
    assign back_ctl.clearing = clearing;
    assign wb_fire           = (state_reg == ST_WB) && (!out_valid_reg || !out_stall);
    assign rf_we             = wb_fire && ex_wr_reg;

    // ---------------- register file (two read copies)
    rvex_ram #(.WIDTH(64), .DEPTH(32)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (dec_reg.rd),
        .wdata (wb_val),
        .re    (rf_re),
        .raddr (q_head.head.rs1),
        .rdata (rf_a_rdata)
    );

    rvex_ram #(.WIDTH(64), .DEPTH(32)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (dec_reg.rd),
        .wdata (wb_val),
        .re    (rf_re),
        .raddr (q_head.head.rs2),
        .rdata (rf_b_rdata)
    );

    // ---------------- execute
    assign a    = rs1_ok_reg ? rf_a_rdata : 64'd0;
    assign b    = rs2_ok_reg ? rf_b_rdata : 64'd0;
    assign opb  = dec_reg.use_imm ? dec_reg.imm : b;
    assign eff  = a + dec_reg.imm;
    assign link = {32'd0, pc_reg} + 64'd4;
    assign pc4  = pc_reg + 32'd4;

    always_comb
    begin
        unique case (dec_reg.alu)
            ALU_ADD:  alu_res = a + opb;
            ALU_SUB:  alu_res = a - opb;
            ALU_SLL:  alu_res = a << opb[5:0];
            ALU_SLT:  alu_res = {63'd0, $signed(a) < $signed(opb)};
            ALU_SLTU: alu_res = {63'd0, a < opb};
            ALU_XOR:  alu_res = a ^ opb;
            ALU_SRL:  alu_res = a >> opb[5:0];
            ALU_SRA:  alu_res = 64'($signed(a) >>> opb[5:0]);
            ALU_OR:   alu_res = a | opb;
            ALU_AND:  alu_res = a & opb;
            default:  alu_res = 64'd0;
        endcase
    end

    always_comb
    begin
        unique case (dec_reg.f3)
            F3_BEQ:  taken = (a == b);
            F3_BNE:  taken = (a != b);
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = !($signed(a) < $signed(b));
            F3_BLTU: taken = (a < b);
            F3_BGEU: taken = (a >= b);
            default: taken = 1'b0;
        endcase
    end

    always_comb
    begin
        ex_val = 64'd0;
        ex_npc = pc4;
        ex_wr  = 1'b0;
        unique case (dec_reg.kind)
            KIND_ALU:
            begin
                ex_val = alu_res;
                ex_wr  = 1'b1;
            end
            KIND_LOAD:
                ex_wr = 1'b1;
            KIND_LUI:
            begin
                ex_val = dec_reg.imm;
                ex_wr  = 1'b1;
            end
            KIND_AUIPC:
            begin
                ex_val = {32'd0, pc_reg} + dec_reg.imm;
                ex_wr  = 1'b1;
            end
            KIND_JAL:
            begin
                ex_val = link;
                ex_wr  = 1'b1;
                ex_npc = pc_reg + dec_reg.imm[31:0];
            end
            KIND_JALR:
            begin
                ex_val = link;
                ex_wr  = 1'b1;
                ex_npc = {eff[31:1], 1'b0};
            end
            KIND_BRANCH:
                if (taken)
                    ex_npc = pc_reg + dec_reg.imm[31:0];
            default:
            begin
                ex_val = 64'd0;
            end
        endcase
    end

    // ---------------- data memory: eight byte lanes, row = address / 8
    assign exec_store = (state_reg == ST_EXEC) && (dec_reg.kind == KIND_STORE);
    assign exec_load  = (state_reg == ST_EXEC) && (dec_reg.kind == KIND_LOAD);
    assign mem_addr   = eff[ADDR_W-1:0];
    assign mem_lo     = mem_addr[2:0];
    assign mem_row    = mem_addr[ADDR_W-1:3];
    assign st_bytes   = 4'd1 << dec_reg.f3[1:0];

    for (genvar g = 0; g < 8; g++)
    begin : g_bank
        logic [2:0]       lane;
        logic [ROW_W-1:0] row_g;
        logic [7:0]       wbyte;

        assign lane  = 3'(g) - mem_lo;
        assign row_g = mem_row + {{(ROW_W-1){1'b0}}, (3'(g) < mem_lo)};
        assign wbyte = 8'(b >> {lane, 3'b000});
        assign bank_we[g] = clearing || (exec_store && ({1'b0, lane} < st_bytes));

        rvex_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (clearing ? clr_row_reg : row_g),
            .wdata (clearing ? 8'd0 : wbyte),
            .re    (exec_load),
            .raddr (row_g),
            .rdata (bank_rdata[g])
        );
    end

    // ---------------- writeback
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            ld_raw[8*i +: 8] = bank_rdata[3'(i) + ex_addr_reg[2:0]];
        end
    end

    always_comb
    begin
        unique case (dec_reg.f3)
            F3_LB:   ld_val = {{56{ld_raw[7]}}, ld_raw[7:0]};
            F3_LH:   ld_val = {{48{ld_raw[15]}}, ld_raw[15:0]};
            F3_LW:   ld_val = {{32{ld_raw[31]}}, ld_raw[31:0]};
            F3_LD:   ld_val = ld_raw;
            F3_LBU:  ld_val = {56'd0, ld_raw[7:0]};
            F3_LHU:  ld_val = {48'd0, ld_raw[15:0]};
            F3_LWU:  ld_val = {32'd0, ld_raw[31:0]};
            default: ld_val = 64'd0;
        endcase
    end

    assign wb_val   = (dec_reg.kind == KIND_LOAD) ? ld_val : ex_val_reg;
    assign addr_ext = {16'd0, ex_addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pc_reg        <= 32'd0;
            reg_valid_reg <= 32'd0;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_row_reg <= clr_row_reg + 1'b1;
            if (wb_fire)
                pc_reg <= ex_npc_reg;
            if (rf_we)
                reg_valid_reg[dec_reg.rd] <= 1'b1;
            if (wb_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_re)
        begin
            dec_reg    <= q_head.head;
            rs1_ok_reg <= reg_valid_reg[q_head.head.rs1];
            rs2_ok_reg <= reg_valid_reg[q_head.head.rs2];
        end
        if (state_reg == ST_EXEC)
        begin
            ex_val_reg  <= ex_val;
            ex_npc_reg  <= ex_npc;
            ex_wr_reg   <= ex_wr && (dec_reg.rd != 5'd0);
            ex_st_reg   <= (dec_reg.kind == KIND_STORE);
            ex_addr_reg <= mem_addr;
        end
        if (wb_fire)
        begin
            next_pc_reg     <= ex_npc_reg;
            reg_written_reg <= ex_wr_reg;
            reg_index_reg   <= ex_wr_reg ? dec_reg.rd : 5'd0;
            reg_value_reg   <= ex_wr_reg ? wb_val : 64'd0;
            mem_written_reg <= ex_st_reg;
            mem_address_reg <= ex_st_reg ? addr_ext[15:0] : 16'd0;
            mem_bytes_reg   <= ex_st_reg ? st_bytes : 4'd0;
            unsupported_reg <= (dec_reg.kind == KIND_BAD);
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign reg_written = reg_written_reg;
    assign reg_index   = reg_index_reg;
    assign reg_value   = reg_value_reg;
    assign mem_written = mem_written_reg;
    assign mem_address = mem_address_reg;
    assign mem_bytes   = mem_bytes_reg;
    assign unsupported = unsupported_reg;

    `RVEX_ASSERT_SAME(a_no_result_in_clear, state_reg == ST_CLEAR, !out_valid_reg, "result during clear")
    `RVEX_ASSERT_SAME(a_x0_kept_zero, rf_we, dec_reg.rd != 5'd0, "write to x0")
    `RVEX_ASSERT_SAME(a_bad_no_mem, (state_reg == ST_EXEC) && (dec_reg.kind == KIND_BAD), bank_we == 8'd0, "memory write on bad op")
    `RVEX_ASSERT_NEXT(a_wb_returns_to_read, wb_fire, state_reg == ST_READ, "writeback did not retire")

endmodule

`default_nettype wire

### rtl/rv64i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv64i_execute_unit
// RV64I integer execute unit: decode front, two-entry queue, execute back.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    instr_word
//  out      out_valid / out_stall  next_pc, reg_written, reg_index, reg_value,
//                                  mem_written, mem_address, mem_bytes,
//                                  unsupported
//
//  Each instruction passes register read, execute with data access, writeback.
//  Instructions run one at a time since each uses the state the previous leaves.
//  After reset the data memory is zeroed, one row per cycle.
//  Two decoded instructions queue while the back end works or out stalls.
//  Writeback waits while a finished result is held by out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64i_execute_unit #(
    parameter int MEM_BYTES = rvex_pkg::MEM_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instr_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        next_pc,
    output logic               reg_written,
    output logic [4:0]         reg_index,
    output logic signed [63:0] reg_value,
    output logic               mem_written,
    output logic [15:0]        mem_address,
    output logic [3:0]         mem_bytes,
    output logic               unsupported
);

    import rvex_pkg::*;

    q_head_t   q_head;
    back_ctl_t back_ctl;

    rvex_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr_word (instr_word),
        .q_head     (q_head),
        .back_ctl   (back_ctl)
    );

    rvex_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .back_ctl    (back_ctl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .reg_written (reg_written),
        .reg_index   (reg_index),
        .reg_value   (reg_value),
        .mem_written (mem_written),
        .mem_address (mem_address),
        .mem_bytes   (mem_bytes),
        .unsupported (unsupported)
    );

endmodule

`default_nettype wire

### bench/tb_rv64i_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_rv64i_execute_unit
// Instruction-level check of the RV64I execute unit. A queue of instruction
// words feeds a clocked driver; a clocked monitor compares each result
// transaction with the next entry of a queue filled by an architectural model
// of the register file, program counter and data memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rv64i_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rvex_pkg::*;

    localparam int MEMSZ = 65536;
    localparam int WATCHDOG_CYCLES = 40000;

    typedef struct packed {
        logic [31:0] npc;
        logic        rw;
        logic [4:0]  ridx;
        logic [63:0] rval;
        logic        mw;
        logic [15:0] maddr;
        logic [3:0]  mbytes;
        logic        bad;
    } retire_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [31:0] instr_word;
    logic out_valid;
    logic out_stall;
    logic [31:0] next_pc;
    logic reg_written;
    logic [4:0] reg_index;
    logic signed [63:0] reg_value;
    logic mem_written;
    logic [15:0] mem_address;
    logic [3:0] mem_bytes;
    logic unsupported;

    rv64i_execute_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .next_pc(next_pc), .reg_written(reg_written), .reg_index(reg_index),
        .reg_value(reg_value), .mem_written(mem_written),
        .mem_address(mem_address), .mem_bytes(mem_bytes),
        .unsupported(unsupported)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    logic [31:0] pending_instrs[$];
    retire_t     expected_retires[$];
    logic [63:0] arch_regs[32];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem[MEMSZ];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int retired = 0;
    int idle_cycles = 0;
    bit hold_send = 0;

    function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        v = v & ((m << 1) - 1);
        return (v ^ m) - m;
    endfunction

    function automatic bit lt_s(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    task automatic add_instr(input logic [31:0] w);
        pending_instrs.insert(pending_instrs.size(), w);
    endtask

    function automatic retire_t execute_instr(input logic [31:0] ins);
        retire_t r;
        logic [6:0] op;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [63:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, pc, npc, val, base;
        bit wr, bad, st, taken;
        int n;
        op = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = arch_regs[ins[19:15]];
        b = arch_regs[ins[24:20]];
        pc = {32'd0, arch_pc};
        imm_i = sx({52'd0, ins[31:20]}, 12);
        imm_s = sx({52'd0, ins[31:25], ins[11:7]}, 12);
        imm_b = sx({51'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        imm_j = sx({43'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        imm_u = sx({32'd0, ins[31:12], 12'd0}, 32);
        npc = pc + 4;
        val = 0;
        base = 0;
        wr = 0; bad = 0; st = 0; taken = 0; n = 0;
        case (op)
            OPC_OP:
            begin
                wr = 1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[5:0];
                        F3_SLT:  val = {63'd0, lt_s(a, b)};
                        F3_SLTU: val = {63'd0, a < b};
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[5:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    val = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    val = $signed(a) >>> b[5:0];
                else
                    bad = 1;
            end
            OPC_OPIMM:
            begin
                wr = 1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLL:
                        if (ins[31:26] != F6_SRL) bad = 1;
                        else val = a << imm_i[5:0];
                    F3_SLT:  val = {63'd0, lt_s(a, imm_i)};
                    F3_SLTU: val = {63'd0, a < imm_i};
                    F3_XOR:  val = a ^ imm_i;
                    F3_SR:
                        if (ins[31:26] == F6_SRL) val = a >> imm_i[5:0];
                        else if (ins[31:26] == F6_SRA) val = $signed(a) >>> imm_i[5:0];
                        else bad = 1;
                    F3_OR:   val = a | imm_i;
                    default: val = a & imm_i;
                endcase
            end
            OPC_LOAD:
            begin
                if (f3 == 3'd7)
                    bad = 1;
                else
                begin
                    wr = 1;
                    n = 1 << f3[1:0];
                    base = a + imm_i;
                    for (int i = 0; i < n; i++)
                        val |= {56'd0, arch_mem[16'(base + i)]} << (8 * i);
                    if (f3 < 3) val = sx(val, 8 * n);
                end
            end
            OPC_STORE:
            begin
                if (f3 > 3)
                    bad = 1;
                else
                begin
                    st = 1;
                    n = 1 << f3;
                    base = a + imm_s;
                    for (int i = 0; i < n; i++)
                        arch_mem[16'(base + i)] = b[8*i +: 8];
                end
            end
            OPC_LUI:
            begin
                wr = 1; val = imm_u;
            end
            OPC_AUIPC:
            begin
                wr = 1; val = pc + imm_u;
            end
            OPC_JAL:
            begin
                wr = 1; val = pc + 4; npc = pc + imm_j;
            end
            OPC_JALR:
            begin
                if (f3 != F3_JALR)
                    bad = 1;
                else
                begin
                    wr = 1; val = pc + 4; npc = (a + imm_i) & ~64'd1;
                end
            end
            OPC_BRANCH:
            begin
                case (f3)
                    F3_BEQ:  taken = (a == b);
                    F3_BNE:  taken = (a != b);
                    F3_BLT:  taken = lt_s(a, b);
                    F3_BGE:  taken = !lt_s(a, b);
                    F3_BLTU: taken = (a < b);
                    F3_BGEU: taken = (a >= b);
                    default: bad = 1;
                endcase
                if (taken) npc = pc + imm_b;
            end
            default: bad = 1;
        endcase
        if (bad)
        begin
            wr = 0; st = 0; npc = pc + 4; val = 0; n = 0;
        end
        if (rd == 0) wr = 0;
        if (wr) arch_regs[rd] = val;
        arch_pc = npc[31:0];
        r.npc = npc[31:0];
        r.rw = wr;
        r.ridx = wr ? rd : 5'd0;
        r.rval = wr ? val : 64'd0;
        r.mw = st;
        r.maddr = st ? base[15:0] : 16'd0;
        r.mbytes = st ? 4'(n) : 4'd0;
        r.bad = bad;
        return r;
    endfunction

    // driver: prediction happens when a transaction is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            instr_word <= 32'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_retires.insert(expected_retires.size(), execute_instr(instr_word));
                void'(pending_instrs.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_instrs.size() != 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    instr_word <= pending_instrs[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                retired <= retired + 1;
                if (expected_retires.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, next_pc %h", $time, next_pc);
                    errors <= errors + 1;
                end
                else
                begin
                    retire_t e, g;
                    e = expected_retires.pop_front();
                    g = '{next_pc, reg_written, reg_index, reg_value, mem_written,
                          mem_address, mem_bytes, unsupported};
                    if (g !== e)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, g);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog expired with %0d results outstanding", expected_retires.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [4:0] rreg();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 7));
    endfunction

    // random instruction: well-formed for each kind, or a fully random word
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [2:0] f3;
        logic [11:0] imm;
        w = $urandom;
        f3 = w[14:12];
        imm = ($urandom_range(1) == 0) ? 12'($urandom_range(0, 63)) : w[31:20];
        case ($urandom_range(11))
            0, 1:
            begin
                logic [6:0] f7;
                f7 = ($urandom_range(1) && (f3 == F3_ADD || f3 == F3_SR)) ? F7_ALT : F7_BASE;
                return {f7, rreg(), rreg(), f3, rreg(), OPC_OP};
            end
            2, 3:
            begin
                if (f3 == F3_SLL) imm = {6'd0, imm[5:0]};
                if (f3 == F3_SR) imm = {($urandom_range(1) ? F6_SRA : F6_SRL), imm[5:0]};
                return {imm, rreg(), f3, rreg(), OPC_OPIMM};
            end
            4, 5: return {imm, rreg(), 3'($urandom_range(6)), rreg(), OPC_LOAD};
            6, 7: return {imm[11:5], rreg(), rreg(), 3'($urandom_range(3)), imm[4:0], OPC_STORE};
            8: return {w[31:12], rreg(), ($urandom_range(1) ? OPC_LUI : OPC_AUIPC)};
            9: return ($urandom_range(1)) ? {w[31:12], rreg(), OPC_JAL}
                                         : {imm, rreg(), F3_JALR, rreg(), OPC_JALR};
            10:
            begin
                f3 = ($urandom_range(5) < 2) ? 3'($urandom_range(1)) : 3'($urandom_range(4, 7));
                return {w[31:25], rreg(), rreg(), f3, w[11:7], OPC_BRANCH};
            end
            default: return w;
        endcase
    endfunction

    task automatic drain();
        while (pending_instrs.size() != 0 || expected_retires.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int total;
        rst_n = 1'b0;
        arch_pc = 32'd0;
        foreach (arch_regs[i]) arch_regs[i] = 64'd0;
        foreach (arch_mem[i]) arch_mem[i] = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, each register-register operation, special cases
        add_instr({12'hfff, 5'd0, F3_ADD, 5'd1, OPC_OPIMM});
        add_instr({12'h7ff, 5'd0, F3_ADD, 5'd2, OPC_OPIMM});
        add_instr({20'h80000, 5'd3, OPC_LUI});
        add_instr({20'hfffff, 5'd4, OPC_AUIPC});
        add_instr({F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_OP});
        for (int f = 0; f < 8; f++)
            add_instr({F7_BASE, 5'd2, 5'd3, 3'(f), 5'd5, OPC_OP});
        add_instr({F7_ALT, 5'd1, 5'd3, F3_ADD, 5'd6, OPC_OP});
        add_instr({F7_ALT, 5'd1, 5'd3, F3_SR, 5'd6, OPC_OP});
        add_instr({F6_SRA, 6'd63, 5'd3, F3_SR, 5'd7, OPC_OPIMM});
        add_instr({6'h01, 6'd1, 5'd3, F3_SLL, 5'd7, OPC_OPIMM});
        add_instr({7'h7f, 5'd1, 5'd1, F3_LD, 5'h1f, OPC_STORE});
        add_instr({12'hfff, 5'd1, F3_LH, 5'd8, OPC_LOAD});
        add_instr({12'h800, 5'd0, F3_LBU, 5'd9, OPC_LOAD});
        add_instr({12'hfff, 5'd0, 3'd7, 5'd9, OPC_LOAD});
        add_instr({7'd0, 5'd1, 5'd3, 3'd2, 5'd8, OPC_BRANCH});
        add_instr({1'b1, 10'h3fe, 1'b1, 8'hff, 5'd1, OPC_JAL});
        add_instr({12'h801, 5'd1, F3_JALR, 5'd10, OPC_JALR});
        add_instr({1'b0, 6'd2, 5'd0, 5'd0, F3_BEQ, 4'd4, 1'b0, OPC_BRANCH});
        add_instr(32'hffffffff);

        total = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 76 : 0;
            recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 38 : 0;
            for (int k = 0; k < 165; k++)
                add_instr(rand_instr());
            if (ph == 1)
            begin
                repeat (300) @(posedge clk);
                @(negedge clk);
                hold_send = 1'b1;
                while (expected_retires.size() != 0 || in_valid)
                    @(negedge clk);
                hold_send = 1'b0;
            end
            drain();
            total += 165;
        end

        repeat (50) @(posedge clk);
        $display("Ran %0d instructions (directed plus %0d random), %0d results checked,",
                 retired, total, retired);
        $display("covering ALU, load/store, jumps, branches and illegal encodings.");
        if (errors == 0 && expected_retires.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
